### rtl/cvlb_pkg.sv
// ----------------------------------------------------------------------------
// cvlb_pkg
// Shared types, constants and register codes of the 3x3 line-buffer
// convolution block.
// ----------------------------------------------------------------------------
package cvlb_pkg;

   // default geometry and element widths
   localparam int FRAME_ROWS_DEF = 64;
   localparam int FRAME_COLS_DEF = 64;
   localparam int WIN_ROWS_DEF   = 3;
   localparam int WIN_COLS_DEF   = 3;
   localparam int PIXEL_BITS_DEF = 8;
   localparam int COEF_BITS_DEF  = 8;

   // width of the result field, wraps on overflow
   localparam int SUM_BITS = 20;

   // window and kernel are always held as 3x3
   localparam int WIN_MAX = 3;

   // register index codes
   localparam int REG_IDX_BITS = 2;
   localparam logic [REG_IDX_BITS-1:0] REG_COEF_TOP    = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_COEF_MID    = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_COEF_BOTTOM = 2'd2;

   // per-item sideband that travels down the pipeline
   typedef struct packed {
      logic emit;   // item completes a window and yields a result
      logic last;   // final result of the frame
   } tag_type;

endpackage

### rtl/cvlb_csr.sv
// ----------------------------------------------------------------------------
// cvlb_csr
// APB-style register file holding the three kernel coefficient rows.
// ----------------------------------------------------------------------------
module cvlb_csr #(
   parameter int CFG_BITS = 24,
   parameter int DATA_W   = 32,
   parameter int ADDR_W   = 4,
   parameter int ADDR_LSB = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [ADDR_W-1:0]   csr_paddr,
   input  logic [DATA_W-1:0]   csr_pwdata,
   output logic [DATA_W-1:0]   csr_prdata,
   output logic                csr_pready,
   output logic [CFG_BITS-1:0] coef_rows [cvlb_pkg::WIN_MAX]
);

   logic [CFG_BITS-1:0]               coef_ff [cvlb_pkg::WIN_MAX];
   logic [cvlb_pkg::REG_IDX_BITS-1:0] reg_idx;
   logic                              wr_stb;

   assign reg_idx    = csr_paddr[ADDR_W-1:ADDR_LSB];
   assign wr_stb     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign coef_rows  = coef_ff;

   // register writes; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cvlb_pkg::WIN_MAX; i++) coef_ff[i] <= '0;
      end else if (wr_stb) begin
         case (reg_idx)
            cvlb_pkg::REG_COEF_TOP:    coef_ff[0] <= csr_pwdata[CFG_BITS-1:0];
            cvlb_pkg::REG_COEF_MID:    coef_ff[1] <= csr_pwdata[CFG_BITS-1:0];
            cvlb_pkg::REG_COEF_BOTTOM: coef_ff[2] <= csr_pwdata[CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // read-back
   always_comb begin
      case (reg_idx)
         cvlb_pkg::REG_COEF_TOP:    csr_prdata = DATA_W'(coef_ff[0]);
         cvlb_pkg::REG_COEF_MID:    csr_prdata = DATA_W'(coef_ff[1]);
         cvlb_pkg::REG_COEF_BOTTOM: csr_prdata = DATA_W'(coef_ff[2]);
         default:                   csr_prdata = '0;
      endcase
   end

endmodule

### rtl/cvlb_line_store.sv
// ----------------------------------------------------------------------------
// cvlb_line_store
// One entry per column holding the pixels of the two previous rows.
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module cvlb_line_store #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

### rtl/cvlb_mac.sv
// ----------------------------------------------------------------------------
// cvlb_mac
// Kernel multiply stage and sum stage. Products are registered, then the
// adder tree feeds the result register.
// ----------------------------------------------------------------------------
module cvlb_mac #(
   parameter int PIXEL_BITS = 8,
   parameter int COEF_BITS  = 8,
   parameter int WIN_ROWS   = 3,
   parameter int WIN_COLS   = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [3*COEF_BITS-1:0]        coef_rows [cvlb_pkg::WIN_MAX],
   input  logic                          in_valid,
   output logic                          in_ready,
   input  cvlb_pkg::tag_type             in_tag,
   input  logic [PIXEL_BITS-1:0]         win [cvlb_pkg::WIN_MAX][cvlb_pkg::WIN_MAX],
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [cvlb_pkg::SUM_BITS-1:0] rsp_conv_sum,
   output logic                          rsp_frame_last
);

   localparam int PROD_W = PIXEL_BITS + COEF_BITS + 1;
   localparam int TREE_W = (PROD_W + 4 > cvlb_pkg::SUM_BITS) ? PROD_W + 4
                                                             : cvlb_pkg::SUM_BITS;

   logic signed [PROD_W-1:0] prod_in [cvlb_pkg::WIN_MAX][cvlb_pkg::WIN_MAX];
   logic signed [PROD_W-1:0] prod_ff [cvlb_pkg::WIN_MAX][cvlb_pkg::WIN_MAX];
   logic                     c_valid_ff;
   cvlb_pkg::tag_type        c_tag_ff;
   logic signed [TREE_W-1:0] sum_in;
   logic                     out_ready;
   logic                     rsp_valid_ff;
   logic signed [cvlb_pkg::SUM_BITS-1:0] sum_ff;
   logic                     last_ff;

   // multipliers: bottom-right part of the window against kernel from (0,0)
   for (genvar i = 0; i < cvlb_pkg::WIN_MAX; i++) begin : g_row
      for (genvar j = 0; j < cvlb_pkg::WIN_MAX; j++) begin : g_col
         if (i < WIN_ROWS && j < WIN_COLS) begin : g_tap
            localparam int WR = cvlb_pkg::WIN_MAX - WIN_ROWS + i;
            localparam int WC = cvlb_pkg::WIN_MAX - WIN_COLS + j;
            logic signed [PIXEL_BITS:0]  pix_s;
            logic signed [COEF_BITS-1:0] coef_s;
            assign pix_s  = $signed({1'b0, win[WR][WC]});
            assign coef_s = $signed(coef_rows[i][j*COEF_BITS +: COEF_BITS]);
            assign prod_in[i][j] = pix_s * coef_s;
         end else begin : g_unused
            assign prod_in[i][j] = '0;
         end
      end
   end

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign in_ready  = !c_valid_ff || out_ready;

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (in_ready) begin
         c_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         c_tag_ff <= in_tag;
         prod_ff  <= prod_in;
      end
   end

   // adder tree over the nine products
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < cvlb_pkg::WIN_MAX; i++) begin
         for (int j = 0; j < cvlb_pkg::WIN_MAX; j++) begin
            sum_in = sum_in + TREE_W'(prod_ff[i][j]);
         end
      end
   end

   // result register; items without a full window are dropped here
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= c_valid_ff && c_tag_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && c_valid_ff) begin
         sum_ff  <= sum_in[cvlb_pkg::SUM_BITS-1:0];
         last_ff <= c_tag_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_conv_sum   = sum_ff;
   assign rsp_frame_last = last_ff;

endmodule

### rtl/conv2d_valid_line_buffer.sv
// ----------------------------------------------------------------------------
// conv2d_valid_line_buffer
// Streaming 3x3 valid-mode convolution over a raster-order pixel stream.
//
// Usage:
//   req_*  : one unsigned pixel per transfer, frame in raster order.
//   rsp_*  : one signed sum per complete window (row and column both past
//            the window edge); rsp_frame_last marks the frame's final sum.
//   csr_*  : APB-style port, kernel rows at 0x0, 0x4, 0x8 (three signed
//            coefficients per row, column 0 in the low byte). Write only
//            while the stream is idle.
//   Pipeline: a result passes the read stage, window stage, multiply stage
//   and sum register after the edge that transferred its pixel. Throughput
//   is one pixel per cycle while results are taken; the column line store
//   is read as a pixel transfers and written back as it moves on.
//   Reset clears counters, window, pipeline valids and coefficients; the
//   line store is not cleared, its stale entries never reach the sum.
//   A stalled receiver holds the result register; empty stages upstream
//   still fill, then req_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module conv2d_valid_line_buffer #(
   parameter int FRAME_ROWS = cvlb_pkg::FRAME_ROWS_DEF,
   parameter int FRAME_COLS = cvlb_pkg::FRAME_COLS_DEF,
   parameter int WIN_ROWS   = cvlb_pkg::WIN_ROWS_DEF,
   parameter int WIN_COLS   = cvlb_pkg::WIN_COLS_DEF,
   parameter int PIXEL_BITS = cvlb_pkg::PIXEL_BITS_DEF,
   parameter int COEF_BITS  = cvlb_pkg::COEF_BITS_DEF,
   localparam int CFG_BITS  = 3 * COEF_BITS,
   localparam int DATA_W    = (CFG_BITS > 32) ? 64 : 32,
   localparam int ADDR_LSB  = (DATA_W == 64) ? 3 : 2,
   localparam int ADDR_W    = ADDR_LSB + cvlb_pkg::REG_IDX_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIXEL_BITS-1:0] req_pixel,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [cvlb_pkg::SUM_BITS-1:0] rsp_conv_sum,
   output logic                  rsp_frame_last,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_W-1:0]     csr_paddr,
   input  logic [DATA_W-1:0]     csr_pwdata,
   output logic [DATA_W-1:0]     csr_prdata,
   output logic                  csr_pready
);

   localparam int ROW_W = $clog2(FRAME_ROWS);
   localparam int COL_W = $clog2(FRAME_COLS);
   localparam int LS_W  = 2 * PIXEL_BITS;

   logic [CFG_BITS-1:0]   coef_rows [cvlb_pkg::WIN_MAX];

   logic                  req_xfer;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   cvlb_pkg::tag_type     tag_in;

   logic                  a_valid_ff;
   logic [PIXEL_BITS-1:0] a_px_ff;
   logic [COL_W-1:0]      a_col_ff;
   cvlb_pkg::tag_type     a_tag_ff;
   logic                  a_ready;
   logic                  a_move;

   logic [LS_W-1:0]       ls_rd_data;
   logic [PIXEL_BITS-1:0] ls_top;
   logic [PIXEL_BITS-1:0] ls_mid;

   logic [PIXEL_BITS-1:0] win_ff [cvlb_pkg::WIN_MAX][cvlb_pkg::WIN_MAX];
   logic                  b_valid_ff;
   cvlb_pkg::tag_type     b_tag_ff;
   logic                  b_ready;
   logic                  mac_ready;

   // configuration registers
   cvlb_csr #(
      .CFG_BITS (CFG_BITS),
      .DATA_W   (DATA_W),
      .ADDR_W   (ADDR_W),
      .ADDR_LSB (ADDR_LSB)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef_rows   (coef_rows)
   );

   // handshake chain
   assign b_ready   = !b_valid_ff || mac_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign a_move    = a_valid_ff && b_ready;
   assign req_ready = a_ready;
   assign req_xfer  = req_valid && a_ready;

   // raster counters and per-pixel tag
   always_comb begin
      tag_in.emit = (row_ff >= ROW_W'(WIN_ROWS - 1)) && (col_ff >= COL_W'(WIN_COLS - 1));
      tag_in.last = (row_ff == ROW_W'(FRAME_ROWS - 1)) && (col_ff == COL_W'(FRAME_COLS - 1));
      row_in = row_ff;
      col_in = col_ff + 1'b1;
      if (col_ff >= COL_W'(FRAME_COLS - 1)) begin
         col_in = '0;
         if (row_ff >= ROW_W'(FRAME_ROWS - 1)) begin
            row_in = '0;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (req_xfer) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // line store: read at transfer, write back shifted pair as the pixel moves on
   assign ls_top = ls_rd_data[LS_W-1:PIXEL_BITS];
   assign ls_mid = ls_rd_data[PIXEL_BITS-1:0];

   cvlb_line_store #(
      .DEPTH  (FRAME_COLS),
      .WIDTH  (LS_W),
      .ADDR_W (COL_W)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (req_xfer),
      .rd_addr (col_ff),
      .rd_data (ls_rd_data),
      .wr_en   (a_move),
      .wr_addr (a_col_ff),
      .wr_data ({ls_mid, a_px_ff})
   );

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         a_px_ff  <= req_pixel;
         a_col_ff <= col_ff;
         a_tag_ff <= tag_in;
      end
   end

   // window stage: shift left, new column from line store and pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         for (int i = 0; i < cvlb_pkg::WIN_MAX; i++) begin
            for (int j = 0; j < cvlb_pkg::WIN_MAX; j++) win_ff[i][j] <= '0;
         end
      end else begin
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (a_move) begin
            for (int i = 0; i < cvlb_pkg::WIN_MAX; i++) begin
               win_ff[i][0] <= win_ff[i][1];
               win_ff[i][1] <= win_ff[i][2];
            end
            win_ff[0][2] <= ls_top;
            win_ff[1][2] <= ls_mid;
            win_ff[2][2] <= a_px_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         b_tag_ff <= a_tag_ff;
      end
   end

   // multiply and sum
   cvlb_mac #(
      .PIXEL_BITS (PIXEL_BITS),
      .COEF_BITS  (COEF_BITS),
      .WIN_ROWS   (WIN_ROWS),
      .WIN_COLS   (WIN_COLS)
   ) u_mac (
      .clock          (clock),
      .reset          (reset),
      .coef_rows      (coef_rows),
      .in_valid       (b_valid_ff),
      .in_ready       (mac_ready),
      .in_tag         (b_tag_ff),
      .win            (win_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_conv_sum   (rsp_conv_sum),
      .rsp_frame_last (rsp_frame_last)
   );

`ifndef SYNTH
   // counters stay inside the frame
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= COL_W'(FRAME_COLS - 1)) && (row_ff <= ROW_W'(FRAME_ROWS - 1)))
      else $error("raster counter out of frame");

   // last pixel of a frame wraps both counters
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && tag_in.last) |=> (col_ff == '0) && (row_ff == '0))
      else $error("counters did not wrap after last pixel");

   // a held input stage keeps its column and stays valid
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !b_ready) |=> (a_valid_ff && $stable(a_col_ff)))
      else $error("input stage lost a stalled pixel");

   // line store never reads and writes the same column in one cycle
   a_ls_conflict: assert property (@(posedge clock) disable iff (reset)
      !(a_move && req_xfer && (a_col_ff == col_ff)))
      else $error("line store read/write collision");
`endif

endmodule
